>>> rtl/core/quad_motor_mixer_with_arming_defines.svh
// assertion macros for the quad motor mixer
`ifndef QUAD_MOTOR_MIXER_WITH_ARMING_DEFINES_SVH
`define QUAD_MOTOR_MIXER_WITH_ARMING_DEFINES_SVH

// same-cycle implication
`define QMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/qmm_pkg.sv
package qmm_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int PULSE_W    = 12;
    localparam int SPAN_W     = 10;
    localparam int CMD_W      = 16;
    localparam int OP_W       = 3;
    localparam int SEL_W      = 2;
    localparam int MODE_W     = 2;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int PROD_W     = 26;
    localparam int SUM_W      = 29;

    localparam logic [OP_W-1:0] OP_UPDATE = 3'd0;
    localparam logic [OP_W-1:0] OP_INIT   = 3'd1;
    localparam logic [OP_W-1:0] OP_ARM    = 3'd2;
    localparam logic [OP_W-1:0] OP_DIRECT = 3'd3;
    localparam logic [OP_W-1:0] OP_SET    = 3'd4;

    localparam logic [SEL_W-1:0] MOTOR_FL = 2'd0;
    localparam logic [SEL_W-1:0] MOTOR_FR = 2'd1;
    localparam logic [SEL_W-1:0] MOTOR_RR = 2'd2;
    localparam logic [SEL_W-1:0] MOTOR_RL = 2'd3;

    localparam logic [MODE_W-1:0] MODE_CODE_SAFE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_OFF    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_OPER   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_DIRECT = 2'd3;

    localparam logic [2:0] REG_PULSE_MIN   = 3'd0;
    localparam logic [2:0] REG_PULSE_RANGE = 3'd1;
    localparam logic [2:0] REG_PULSE_MAX   = 3'd2;
    localparam logic [2:0] REG_PITCH_SPAN  = 3'd3;
    localparam logic [2:0] REG_ROLL_SPAN   = 3'd4;

    localparam logic [PULSE_W-1:0] RST_PULSE_MIN   = 12'd1000;
    localparam logic [PULSE_W-1:0] RST_PULSE_RANGE = 12'd1000;
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX   = 12'd2000;
    localparam logic [SPAN_W-1:0]  RST_PITCH_SPAN  = 10'd250;
    localparam logic [SPAN_W-1:0]  RST_ROLL_SPAN   = 10'd250;

    typedef enum logic [3:0] {
        MODE_SAFE   = 4'b0001,
        MODE_OFF    = 4'b0010,
        MODE_OPER   = 4'b0100,
        MODE_DIRECT = 4'b1000
    } t_mode;

    typedef logic [PULSE_W-1:0] t_pulse;

    // pulse_max + 1, saturated to the pulse width
    function automatic t_pulse clip_of(input t_pulse pmax);
        t_pulse c;
        c = &pmax ? pmax : pmax + t_pulse'(1);
        return c;
    endfunction

    // scale down by 2^15, floor at zero, clip above pulse_max
    function automatic t_pulse finish(input logic signed [SUM_W-1:0] num,
                                      input t_pulse pmax);
        logic [PULSE_W:0] v;
        t_pulse           r;
        v = num[SUM_W-2:15];
        if (num[SUM_W-1] || num == '0) begin
            r = '0;
        end else if (v > {1'b0, pmax}) begin
            r = clip_of(pmax);
        end else begin
            r = v[PULSE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_SAFE:   c = MODE_CODE_SAFE;
            MODE_OFF:    c = MODE_CODE_OFF;
            MODE_OPER:   c = MODE_CODE_OPER;
            MODE_DIRECT: c = MODE_CODE_DIRECT;
            default:     c = MODE_CODE_SAFE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/quad_motor_mixer_with_arming.sv
// Quad X motor mixer with an arming mode machine.
// Input channel (i_in_valid / o_in_ready) carries one command transaction:
// opcode, throttle, pitch, roll, and motor select / value for direct mode.
// Output channel (o_out_valid / i_out_ready) returns one transaction per
// command: the four stored pulse widths, the mode after the command and a
// flag that is set when the pulses are driven to the motors.
// Configuration (pulse_min, pulse_range, pulse_max, pitch_span, roll_span)
// is written and read through the APB-style port at byte addresses 0..16,
// pready is always high; write it only while no command is in flight.
// A command is registered in the input register and then in the output
// register. Throughput: one command per cycle when the receiver is ready;
// the input register holds the three products, the output stage adds,
// clips and updates the mode. Reset puts the block in safe start with all
// pulses zero and the configuration at its defaults. When the receiver
// stalls, the output register holds its result, the command in the input
// register waits, and o_in_ready drops once both are full.
module quad_motor_mixer_with_arming (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [qmm_pkg::OP_W-1:0]            i_opcode,
    input  logic [qmm_pkg::CMD_W-1:0]           i_throttle_cmd,
    input  logic signed [qmm_pkg::CMD_W-1:0]    i_pitch_cmd,
    input  logic signed [qmm_pkg::CMD_W-1:0]    i_roll_cmd,
    input  logic [qmm_pkg::SEL_W-1:0]           i_motor_select,
    input  logic [qmm_pkg::PULSE_W-1:0]         i_motor_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [qmm_pkg::PULSE_W-1:0]         o_pulse_fl,
    output logic [qmm_pkg::PULSE_W-1:0]         o_pulse_fr,
    output logic [qmm_pkg::PULSE_W-1:0]         o_pulse_rr,
    output logic [qmm_pkg::PULSE_W-1:0]         o_pulse_rl,
    output logic [qmm_pkg::MODE_W-1:0]          o_mode_now,
    output logic                                o_pulses_written,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qmm_pkg::PADDR_W-1:0]         paddr,
    input  logic [qmm_pkg::PDATA_W-1:0]         pwdata,
    output logic [qmm_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import qmm_pkg::*;
    `include "quad_motor_mixer_with_arming_defines.svh"

    // configuration
    t_pulse            r_pulse_min;
    t_pulse            r_pulse_range;
    t_pulse            r_pulse_max;
    logic [SPAN_W-1:0] r_pitch_span;
    logic [SPAN_W-1:0] r_roll_span;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min   <= RST_PULSE_MIN;
            r_pulse_range <= RST_PULSE_RANGE;
            r_pulse_max   <= RST_PULSE_MAX;
            r_pitch_span  <= RST_PITCH_SPAN;
            r_roll_span   <= RST_ROLL_SPAN;
        end else if (cfg_wr) begin
            unique case (paddr[PADDR_W-1:2])
                REG_PULSE_MIN:   r_pulse_min   <= pwdata[PULSE_W-1:0];
                REG_PULSE_RANGE: r_pulse_range <= pwdata[PULSE_W-1:0];
                REG_PULSE_MAX:   r_pulse_max   <= pwdata[PULSE_W-1:0];
                REG_PITCH_SPAN:  r_pitch_span  <= pwdata[SPAN_W-1:0];
                REG_ROLL_SPAN:   r_roll_span   <= pwdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[PADDR_W-1:2])
            REG_PULSE_MIN:   prdata = PDATA_W'(r_pulse_min);
            REG_PULSE_RANGE: prdata = PDATA_W'(r_pulse_range);
            REG_PULSE_MAX:   prdata = PDATA_W'(r_pulse_max);
            REG_PITCH_SPAN:  prdata = PDATA_W'(r_pitch_span);
            REG_ROLL_SPAN:   prdata = PDATA_W'(r_roll_span);
            default:         prdata = '0;
        endcase
    end

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic s2_adv;
    logic in_acc;

    assign s2_adv     = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_s1_valid | s2_adv;
    assign in_acc     = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;

    // input stage: command plus products
    logic [OP_W-1:0]           r_op;
    logic [SEL_W-1:0]          r_sel;
    t_pulse                    r_value;
    t_pulse                    r_thr_part;
    logic signed [PROD_W-1:0]  r_pp;
    logic signed [PROD_W-1:0]  r_rr;
    logic [PULSE_W+CMD_W-1:0]  thr_prod;
    logic signed [CMD_W+SPAN_W:0] pp_full;
    logic signed [CMD_W+SPAN_W:0] rr_full;

    assign thr_prod = r_pulse_range * i_throttle_cmd;
    assign pp_full  = i_pitch_cmd * $signed({1'b0, r_pitch_span});
    assign rr_full  = i_roll_cmd * $signed({1'b0, r_roll_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_opcode;
            r_sel      <= i_motor_select;
            r_value    <= i_motor_value;
            r_thr_part <= thr_prod[PULSE_W+CMD_W-1:CMD_W];
            r_pp       <= pp_full[PROD_W-1:0];
            r_rr       <= rr_full[PROD_W-1:0];
        end
    end

    // mixing
    logic [PULSE_W:0]         base_sum;
    t_pulse                   base;
    logic signed [SUM_W-1:0]  b_s;
    logic signed [SUM_W-1:0]  pp_s;
    logic signed [SUM_W-1:0]  rr_s;
    t_pulse                   mix [NUM_MOTORS];

    assign base_sum = {1'b0, r_pulse_min} + {1'b0, r_thr_part};
    assign base     = (base_sum > {1'b0, r_pulse_max}) ? clip_of(r_pulse_max)
                                                       : base_sum[PULSE_W-1:0];
    assign b_s  = $signed({2'b00, base, 15'd0});
    assign pp_s = SUM_W'(r_pp);
    assign rr_s = SUM_W'(r_rr);

    assign mix[MOTOR_FL] = finish(b_s - pp_s + rr_s, r_pulse_max);
    assign mix[MOTOR_FR] = finish(b_s - pp_s - rr_s, r_pulse_max);
    assign mix[MOTOR_RR] = finish(b_s + pp_s - rr_s, r_pulse_max);
    assign mix[MOTOR_RL] = finish(b_s + pp_s + rr_s, r_pulse_max);

    // mode machine and stored pulses
    t_mode  r_mode;
    t_mode  n_mode;
    t_pulse r_pulse [NUM_MOTORS];
    t_pulse n_pulse [NUM_MOTORS];
    logic   n_written;

    always_comb begin
        n_mode    = r_mode;
        n_pulse   = r_pulse;
        n_written = 1'b0;
        unique case (r_op)
            OP_UPDATE: begin
                unique case (r_mode)
                    MODE_OPER: begin
                        n_pulse   = mix;
                        n_written = 1'b1;
                    end
                    MODE_OFF: begin
                        for (int i = 0; i < NUM_MOTORS; i++) n_pulse[i] = '0;
                        n_written = 1'b1;
                    end
                    MODE_DIRECT: n_written = 1'b1;
                    default: ;
                endcase
            end
            OP_INIT: begin
                if (r_mode == MODE_SAFE) n_mode = MODE_OFF;
            end
            OP_ARM: begin
                if (r_mode != MODE_SAFE) begin
                    if (r_mode == MODE_OFF) begin
                        for (int i = 0; i < NUM_MOTORS; i++) n_pulse[i] = r_pulse_min;
                        n_written = 1'b1;
                    end
                    n_mode = MODE_OPER;
                end
            end
            OP_DIRECT: begin
                if (r_mode == MODE_OPER || r_mode == MODE_DIRECT) begin
                    for (int i = 0; i < NUM_MOTORS; i++) n_pulse[i] = r_pulse_min;
                    n_mode = MODE_DIRECT;
                end
            end
            OP_SET: begin
                if (r_mode == MODE_DIRECT) n_pulse[r_sel] = r_value;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SAFE;
            for (int i = 0; i < NUM_MOTORS; i++) r_pulse[i] <= '0;
        end else if (s2_adv) begin
            r_mode  <= n_mode;
            r_pulse <= n_pulse;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            o_pulse_fl       <= n_pulse[MOTOR_FL];
            o_pulse_fr       <= n_pulse[MOTOR_FR];
            o_pulse_rr       <= n_pulse[MOTOR_RR];
            o_pulse_rl       <= n_pulse[MOTOR_RL];
            o_mode_now       <= mode_code(n_mode);
            o_pulses_written <= n_written;
        end
    end

    `QMM_ASSERT_NOW(a_no_drive_in_safe, i_clk, i_rst_n,
        o_out_valid && o_pulses_written, o_mode_now != MODE_CODE_SAFE,
        "pulses driven in safe start")
    `QMM_ASSERT_NEXT(a_safe_not_reentered, i_clk, i_rst_n,
        r_mode != MODE_SAFE, r_mode != MODE_SAFE,
        "mode returned to safe start")
    `QMM_ASSERT_NOW(a_off_drives_zero, i_clk, i_rst_n,
        o_out_valid && o_pulses_written && o_mode_now == MODE_CODE_OFF,
        o_pulse_fl == '0 && o_pulse_fr == '0 &&
        o_pulse_rr == '0 && o_pulse_rl == '0,
        "nonzero pulse driven in off mode")
    `QMM_ASSERT_NEXT(a_s1_held_on_stall, i_clk, i_rst_n,
        r_s1_valid && !s2_adv,
        r_s1_valid && $stable(r_op) && $stable(r_pp) && $stable(r_rr),
        "stalled command lost")
    `QMM_ASSERT_NEXT(a_state_frozen_idle, i_clk, i_rst_n,
        !s2_adv, $stable(r_mode),
        "mode changed without a command")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import qmm_pkg::*;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [CMD_W-1:0]        throttle;
        logic signed [CMD_W-1:0] pitch;
        logic signed [CMD_W-1:0] roll;
        logic [SEL_W-1:0]        sel;
        t_pulse                  value;
    } t_mixer_cmd;

    typedef struct {
        t_pulse            fl;
        t_pulse            fr;
        t_pulse            rr;
        t_pulse            rl;
        logic [MODE_W-1:0] mode;
        logic              written;
    } t_mixer_out;

    class motor_mixer_scoreboard;
        localparam longint Q15_ONE = 32768;
        localparam int     Q16_SHIFT = 16;
        localparam int     PULSE_TOP = (1 << PULSE_W) - 1;

        t_pulse            pulse_min;
        t_pulse            pulse_range;
        t_pulse            pulse_max;
        logic [SPAN_W-1:0] pitch_span;
        logic [SPAN_W-1:0] roll_span;
        logic [MODE_W-1:0] mode;
        t_pulse            pulse [NUM_MOTORS];
        t_mixer_out        expected_outputs [$];
        int                errors;

        function new();
            pulse_min   = RST_PULSE_MIN;
            pulse_range = RST_PULSE_RANGE;
            pulse_max   = RST_PULSE_MAX;
            pitch_span  = RST_PITCH_SPAN;
            roll_span   = RST_ROLL_SPAN;
            mode        = MODE_CODE_SAFE;
            foreach (pulse[i]) pulse[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
            case (idx)
                REG_PULSE_MIN:   pulse_min   = value[PULSE_W-1:0];
                REG_PULSE_RANGE: pulse_range = value[PULSE_W-1:0];
                REG_PULSE_MAX:   pulse_max   = value[PULSE_W-1:0];
                REG_PITCH_SPAN:  pitch_span  = value[SPAN_W-1:0];
                REG_ROLL_SPAN:   roll_span   = value[SPAN_W-1:0];
                default: ;
            endcase
        endfunction

        // one above the limit, held at full scale
        function t_pulse clip_level();
            int unsigned lvl;
            lvl = pulse_max;
            lvl = lvl + 1;
            if (lvl > PULSE_TOP) lvl = PULSE_TOP;
            return t_pulse'(lvl);
        endfunction

        function t_pulse scale_pulse(input longint sum);
            longint lvl;
            longint lim;
            lim = pulse_max;
            if (sum <= 0) return '0;
            lvl = sum / Q15_ONE;
            if (lvl > lim) return clip_level();
            return t_pulse'(lvl);
        endfunction

        function void mix_pulses(input logic [CMD_W-1:0] thr,
                                 input logic signed [CMD_W-1:0] pit,
                                 input logic signed [CMD_W-1:0] rol);
            longint thr_l, pit_l, rol_l, min_l, rng_l, max_l, ps_l, rs_l;
            longint base, b, pp, rr;
            thr_l = thr;
            pit_l = pit;
            rol_l = rol;
            min_l = pulse_min;
            rng_l = pulse_range;
            max_l = pulse_max;
            ps_l  = pitch_span;
            rs_l  = roll_span;
            base = min_l + ((rng_l * thr_l) >>> Q16_SHIFT);
            if (base > max_l) base = clip_level();
            b  = base * Q15_ONE;
            pp = pit_l * ps_l;
            rr = rol_l * rs_l;
            pulse[MOTOR_FL] = scale_pulse(b - pp + rr);
            pulse[MOTOR_FR] = scale_pulse(b - pp - rr);
            pulse[MOTOR_RR] = scale_pulse(b + pp - rr);
            pulse[MOTOR_RL] = scale_pulse(b + pp + rr);
        endfunction

        function void fill_pulses(input t_pulse v);
            foreach (pulse[i]) pulse[i] = v;
        endfunction

        function void note_command(input t_mixer_cmd c);
            t_mixer_out r;
            logic       written;
            written = 1'b0;
            case (c.op)
                OP_UPDATE: begin
                    if (mode == MODE_CODE_OPER) begin
                        mix_pulses(c.throttle, c.pitch, c.roll);
                        written = 1'b1;
                    end else if (mode == MODE_CODE_OFF) begin
                        fill_pulses('0);
                        written = 1'b1;
                    end else if (mode == MODE_CODE_DIRECT) begin
                        written = 1'b1;
                    end
                end
                OP_INIT: begin
                    if (mode == MODE_CODE_SAFE) mode = MODE_CODE_OFF;
                end
                OP_ARM: begin
                    if (mode != MODE_CODE_SAFE) begin
                        if (mode == MODE_CODE_OFF) begin
                            fill_pulses(pulse_min);
                            written = 1'b1;
                        end
                        mode = MODE_CODE_OPER;
                    end
                end
                OP_DIRECT: begin
                    if (mode == MODE_CODE_OPER || mode == MODE_CODE_DIRECT) begin
                        fill_pulses(pulse_min);
                        mode = MODE_CODE_DIRECT;
                    end
                end
                OP_SET: begin
                    if (mode == MODE_CODE_DIRECT) pulse[c.sel] = c.value;
                end
                default: ;
            endcase
            r.fl      = pulse[MOTOR_FL];
            r.fr      = pulse[MOTOR_FR];
            r.rr      = pulse[MOTOR_RR];
            r.rl      = pulse[MOTOR_RL];
            r.mode    = mode;
            r.written = written;
            expected_outputs.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_outputs(input t_mixer_out got);
            t_mixer_out want;
            if (expected_outputs.size() == 0) begin
                $error("result transaction with no command pending");
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            compare_field("pulse_fl", want.fl, got.fl);
            compare_field("pulse_fr", want.fr, got.fr);
            compare_field("pulse_rr", want.rr, got.rr);
            compare_field("pulse_rl", want.rl, got.rl);
            compare_field("mode_now", want.mode, got.mode);
            compare_field("pulses_written", want.written, got.written);
        endfunction
    endclass

    localparam int STALL_LIMIT     = 1000;
    localparam int ITEMS_PER_PHASE = 47;
    localparam int NUM_PHASES      = 8;
    localparam int PULSE_TOP       = (1 << PULSE_W) - 1;
    localparam int SPAN_TOP        = (1 << SPAN_W) - 1;
    localparam int OP_TOP          = (1 << OP_W) - 1;

    logic                      i_clk;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_ready;
    logic [OP_W-1:0]           i_opcode       = OP_UPDATE;
    logic [CMD_W-1:0]          i_throttle_cmd = '0;
    logic signed [CMD_W-1:0]   i_pitch_cmd    = '0;
    logic signed [CMD_W-1:0]   i_roll_cmd     = '0;
    logic [SEL_W-1:0]          i_motor_select = MOTOR_FL;
    logic [PULSE_W-1:0]        i_motor_value  = '0;
    logic                      o_out_valid;
    logic                      i_out_ready    = 1'b1;
    logic [PULSE_W-1:0]        o_pulse_fl;
    logic [PULSE_W-1:0]        o_pulse_fr;
    logic [PULSE_W-1:0]        o_pulse_rr;
    logic [PULSE_W-1:0]        o_pulse_rl;
    logic [MODE_W-1:0]         o_mode_now;
    logic                      o_pulses_written;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic [PADDR_W-1:0]        paddr          = '0;
    logic [PDATA_W-1:0]        pwdata         = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    bit                        send_steady    = 1'b0;
    bit                        recv_steady    = 1'b0;
    int                        stall_cycles   = 0;
    motor_mixer_scoreboard     mixer_sb       = new();

    quad_motor_mixer_with_arming u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_throttle_cmd   (i_throttle_cmd),
        .i_pitch_cmd      (i_pitch_cmd),
        .i_roll_cmd       (i_roll_cmd),
        .i_motor_select   (i_motor_select),
        .i_motor_value    (i_motor_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pulse_fl       (o_pulse_fl),
        .o_pulse_fr       (o_pulse_fr),
        .o_pulse_rr       (o_pulse_rr),
        .o_pulse_rl       (o_pulse_rl),
        .o_mode_now       (o_mode_now),
        .o_pulses_written (o_pulses_written),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : out_side
        forever begin
            @(posedge i_clk);
            if (!recv_steady && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_mixer_cmd cmd;
        t_mixer_out res;
        bit         moved;
        if (i_rst_n) begin
            moved = psel;
            if (i_in_valid && o_in_ready) begin
                cmd.op       = i_opcode;
                cmd.throttle = i_throttle_cmd;
                cmd.pitch    = i_pitch_cmd;
                cmd.roll     = i_roll_cmd;
                cmd.sel      = i_motor_select;
                cmd.value    = i_motor_value;
                mixer_sb.note_command(cmd);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                res.fl      = o_pulse_fl;
                res.fr      = o_pulse_fr;
                res.rr      = o_pulse_rr;
                res.rl      = o_pulse_rl;
                res.mode    = o_mode_now;
                res.written = o_pulses_written;
                mixer_sb.check_outputs(res);
                moved = 1'b1;
            end
            if (moved) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_cmd(input t_mixer_cmd c);
        i_in_valid     <= 1'b1;
        i_opcode       <= c.op;
        i_throttle_cmd <= c.throttle;
        i_pitch_cmd    <= c.pitch;
        i_roll_cmd     <= c.roll;
        i_motor_select <= c.sel;
        i_motor_value  <= c.value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [CMD_W-1:0] thr,
                           input logic [CMD_W-1:0] pit, input logic [CMD_W-1:0] rol,
                           input logic [SEL_W-1:0] sel, input t_pulse value);
        t_mixer_cmd c;
        c.op       = op;
        c.throttle = thr;
        c.pitch    = pit;
        c.roll     = rol;
        c.sel      = sel;
        c.value    = value;
        send_cmd(c);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mixer_sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic program_regs(input int unsigned pmin, input int unsigned prange,
                                input int unsigned pmax, input int unsigned pspan,
                                input int unsigned rspan);
        write_reg(REG_PULSE_MIN, pmin);
        write_reg(REG_PULSE_RANGE, prange);
        write_reg(REG_PULSE_MAX, pmax);
        write_reg(REG_PITCH_SPAN, pspan);
        write_reg(REG_ROLL_SPAN, rspan);
    endtask

    // first edge lets the monitor record the last accepted command
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mixer_sb.expected_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick16(input logic [CMD_W-1:0] lo,
                                                input logic [CMD_W-1:0] hi);
        int unsigned roll_die;
        roll_die = $urandom_range(0, 9);
        if (roll_die == 0) return lo;
        if (roll_die == 1) return hi;
        return CMD_W'($urandom);
    endfunction

    function automatic t_mixer_cmd random_cmd();
        t_mixer_cmd  c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      c.op = OP_UPDATE;
        else if (pick < 59) c.op = OP_SET;
        else if (pick < 70) c.op = OP_DIRECT;
        else if (pick < 82) c.op = OP_ARM;
        else if (pick < 90) c.op = OP_INIT;
        else                c.op = OP_W'($urandom_range(int'(OP_SET) + 1, OP_TOP));
        c.throttle = pick16('0, '1);
        c.pitch    = pick16(16'h8000, 16'h7FFF);
        c.roll     = pick16(16'h8000, 16'h7FFF);
        c.sel      = SEL_W'($urandom);
        c.value    = PULSE_W'($urandom);
        return c;
    endfunction

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        program_regs(32'(RST_PULSE_MIN), 32'(RST_PULSE_RANGE), 32'(RST_PULSE_MAX),
                     32'(RST_PITCH_SPAN), 32'(RST_ROLL_SPAN));

        // safe start ignores everything but init
        send_op(OP_UPDATE, 16'hFFFF, 16'h7FFF, 16'h8000, MOTOR_RL, 12'hFFF);
        send_op(OP_ARM, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_DIRECT, 16'h1234, 16'h4321, 16'hC000, MOTOR_RR, 12'h555);
        send_op(OP_SET, 16'h8000, 16'h0001, 16'hFFFF, MOTOR_FR, 12'd123);
        for (int k = 1; k <= OP_TOP - int'(OP_SET); k++)
            send_op(OP_W'(int'(OP_SET) + k), 16'hAAAA, 16'h5555, 16'hAAAA, MOTOR_RL,
                    12'hAAA);
        send_op(OP_INIT, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_INIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, MOTOR_RL, 12'hFFF);
        send_op(OP_UPDATE, 16'hFFFF, 16'h7FFF, 16'h7FFF, MOTOR_FL, 12'h000);
        send_op(OP_DIRECT, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_SET, 16'h0000, 16'h0000, 16'h0000, MOTOR_RR, 12'd999);
        send_op(OP_ARM, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        // full scale demands in operation
        send_op(OP_UPDATE, 16'hFFFF, 16'h8000, 16'h7FFF, MOTOR_FL, 12'h000);
        send_op(OP_UPDATE, 16'h0000, 16'h7FFF, 16'h8000, MOTOR_FL, 12'h000);
        send_op(OP_UPDATE, 16'h8000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_DIRECT, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_SET, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_SET, 16'h0000, 16'h0000, 16'h0000, MOTOR_FR, 12'hFFF);
        send_op(OP_SET, 16'h0000, 16'h0000, 16'h0000, MOTOR_RR, 12'h7FF);
        send_op(OP_SET, 16'h0000, 16'h0000, 16'h0000, MOTOR_RL, 12'h001);
        send_op(OP_UPDATE, 16'hFFFF, 16'h8000, 16'h8000, MOTOR_FL, 12'h000);
        send_op(OP_ARM, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_INIT, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);
        send_op(OP_ARM, 16'h0000, 16'h0000, 16'h0000, MOTOR_FL, 12'h000);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: program_regs(PULSE_TOP, PULSE_TOP, PULSE_TOP, SPAN_TOP, SPAN_TOP);
                1: program_regs(0, 0, 0, 0, 0);
                2: program_regs(32'(RST_PULSE_MIN), 32'(RST_PULSE_RANGE), PULSE_TOP - 1,
                                32'(RST_PITCH_SPAN), 32'(RST_ROLL_SPAN));
                3: program_regs($urandom_range(0, 2000), $urandom_range(0, PULSE_TOP),
                                $urandom_range(1000, PULSE_TOP), $urandom_range(0, SPAN_TOP),
                                $urandom_range(0, SPAN_TOP));
                default: program_regs($urandom_range(0, PULSE_TOP),
                                      $urandom_range(0, PULSE_TOP),
                                      $urandom_range(0, PULSE_TOP),
                                      $urandom_range(0, SPAN_TOP),
                                      $urandom_range(0, SPAN_TOP));
            endcase
            send_steady = (ph == 3) || (ph >= NUM_PHASES - 2);
            recv_steady = send_steady;
            repeat (ITEMS_PER_PHASE) begin
                send_cmd(random_cmd());
                if (!send_steady && $urandom_range(0, 4) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mixer_sb.errors == 0 && mixer_sb.expected_outputs.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/qmm_pkg.sv
rtl/core/quad_motor_mixer_with_arming.sv
verif/tb_top.sv
